// ===== hdl/hpd_pkg.sv =====
`timescale 1ns / 1ps

package hpd_pkg;

  // Depth of the queue between the classifier and the framer
  localparam int unsigned FifoDepth = 2;

  localparam logic [7:0]  TypeEvent   = 8'h04;
  localparam logic [7:0]  TypeAcl     = 8'h02;
  localparam logic [15:0] MaxLenReset = 16'd1021;

  // Header byte index (counted after the type byte)
  localparam logic [1:0] EvtHdrLastIdx = 2'd1;
  localparam logic [1:0] AclLenLoIdx   = 2'd2;
  localparam logic [1:0] AclHdrLastIdx = 2'd3;

  // Register select: paddr[2] is the word index
  localparam logic RegMaxPayloadLen = 1'b0;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_ACL   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  // Classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       is_evt;
    logic       is_acl;
  } item_t;

  // One framed output byte
  typedef struct packed {
    logic [15:0] payload_len;
    logic        too_long;
    logic        bad_type;
    logic        last;
    logic        first;
    logic        is_header;
    kind_e       kind;
    logic [7:0]  data;
  } result_t;

endpackage

// ===== hdl/hpd_front.sv =====
`timescale 1ns / 1ps

module hpd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hpd_pkg::item_t out_item_o
);

  logic           valid_q, valid_d;
  hpd_pkg::item_t item_q;
  logic           take;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Type byte decode happens here so the framer only sees flags
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data   <= in_data_i;
      item_q.is_evt <= (in_data_i == hpd_pkg::TypeEvent);
      item_q.is_acl <= (in_data_i == hpd_pkg::TypeAcl);
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== hdl/hpd_fifo.sv =====
`timescale 1ns / 1ps

module hpd_fifo #(
  parameter int unsigned Depth = hpd_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  hpd_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output hpd_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  hpd_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

// ===== hdl/hpd_back.sv =====
`timescale 1ns / 1ps

module hpd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      max_len_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hpd_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hpd_pkg::result_t out_res_o
);

  hpd_pkg::phase_e  phase_q, phase_d;
  logic [15:0]      remaining_q, remaining_d;
  logic [1:0]       hdr_idx_q, hdr_idx_d;
  logic [7:0]       len_lo_q, len_lo_d;
  hpd_pkg::kind_e   kind_q, kind_d;
  logic             oversize_q, oversize_d;
  logic             out_valid_q, out_valid_d;
  hpd_pkg::result_t res_q, res_d;
  logic             take;
  logic             hdr_last;
  logic [15:0]      len;
  logic [15:0]      rem_dec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign hdr_last = (kind_q == hpd_pkg::KIND_EVENT) ? (hdr_idx_q == hpd_pkg::EvtHdrLastIdx)
                                                    : (hdr_idx_q == hpd_pkg::AclHdrLastIdx);
  assign len      = (kind_q == hpd_pkg::KIND_EVENT) ? {8'h00, in_item_i.data}
                                                    : {in_item_i.data, len_lo_q};
  assign rem_dec  = remaining_q - 16'd1;

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    hdr_idx_d   = hdr_idx_q;
    len_lo_d    = len_lo_q;
    kind_d      = kind_q;
    oversize_d  = oversize_q;

    res_d             = '0;
    res_d.data        = in_item_i.data;
    res_d.kind        = hpd_pkg::KIND_NONE;

    case (phase_q)
      hpd_pkg::PH_HEADER: begin
        res_d.kind      = kind_q;
        res_d.is_header = 1'b1;
        if (kind_q != hpd_pkg::KIND_EVENT && hdr_idx_q == hpd_pkg::AclLenLoIdx) begin
          len_lo_d = in_item_i.data;
        end
        hdr_idx_d = hdr_idx_q + 2'd1;
        if (hdr_last) begin
          res_d.payload_len = len;
          res_d.too_long    = (len > max_len_i);
          if (len == 16'd0) begin
            res_d.last  = 1'b1;
            phase_d     = hpd_pkg::PH_TYPE;
            remaining_d = '0;
            hdr_idx_d   = '0;
            len_lo_d    = '0;
            kind_d      = hpd_pkg::KIND_NONE;
            oversize_d  = 1'b0;
          end else begin
            phase_d     = hpd_pkg::PH_PAYLOAD;
            remaining_d = len;
            oversize_d  = (len > max_len_i);
            hdr_idx_d   = '0;
          end
        end
      end
      hpd_pkg::PH_PAYLOAD: begin
        res_d.kind     = kind_q;
        res_d.too_long = oversize_q;
        remaining_d    = rem_dec;
        if (rem_dec == 16'd0) begin
          res_d.last  = 1'b1;
          phase_d     = hpd_pkg::PH_TYPE;
          hdr_idx_d   = '0;
          len_lo_d    = '0;
          kind_d      = hpd_pkg::KIND_NONE;
          oversize_d  = 1'b0;
        end
      end
      default: begin
        // waiting for a type byte; unknown codes land here too
        remaining_d = '0;
        hdr_idx_d   = '0;
        len_lo_d    = '0;
        oversize_d  = 1'b0;
        if (in_item_i.is_evt || in_item_i.is_acl) begin
          kind_d          = in_item_i.is_evt ? hpd_pkg::KIND_EVENT : hpd_pkg::KIND_ACL;
          phase_d         = hpd_pkg::PH_HEADER;
          res_d.kind      = kind_d;
          res_d.is_header = 1'b1;
          res_d.first     = 1'b1;
        end else begin
          kind_d         = hpd_pkg::KIND_NONE;
          phase_d        = hpd_pkg::PH_TYPE;
          res_d.bad_type = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hpd_pkg::PH_TYPE;
      remaining_q <= '0;
      hdr_idx_q   <= '0;
      len_lo_q    <= '0;
      kind_q      <= hpd_pkg::KIND_NONE;
      oversize_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q     <= phase_d;
        remaining_q <= remaining_d;
        hdr_idx_q   <= hdr_idx_d;
        len_lo_q    <= len_lo_d;
        kind_q      <= kind_d;
        oversize_q  <= oversize_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hpd_pkg::PH_PAYLOAD) |-> (remaining_q != 16'd0))
    else $error("payload phase with nothing left");

  a_first_is_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.first) |-> (res_q.is_header && res_q.kind != hpd_pkg::KIND_NONE))
    else $error("first mark outside a type byte");

  a_hdr_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.last && res_q.is_header) |-> (res_q.payload_len == 16'd0))
    else $error("last on header byte with nonzero length");

  a_bad_no_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.bad_type) |-> (res_q.kind == hpd_pkg::KIND_NONE && !res_q.is_header))
    else $error("dropped byte tagged as packet");

endmodule

// ===== hdl/hci_h4_packet_deframer_core.sv =====
`timescale 1ns / 1ps

// HCI H4 deframer: takes one received UART byte per item and passes it on,
// tagged with packet kind, header/first/last marks, bad type and oversize
// flags, and the decoded payload length on the final header byte. It
// sustains one item per clock while m_axis_tready is high; an accepted
// byte passes through the input stage, the queue and the output register.
// The limit is set by the framer step that updates length and phase state
// for each byte. max_payload_len sits at address 0 and may only be written
// while no bytes are in flight.
module hci_h4_packet_deframer_core #(
  parameter int unsigned FifoDepth = hpd_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] payload_len
  output logic [5:0]  m_axis_tuser,   // [1:0] packet_kind, [2] is_header, [3] first,
                                      // [4] bad_type, [5] too_long
  output logic        m_axis_tlast,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]      max_len_q;
  logic             front_valid, front_ready;
  hpd_pkg::item_t   front_item;
  logic             q_valid, q_ready;
  hpd_pkg::item_t   q_item;
  hpd_pkg::result_t res;
  logic             reg_sel;
  logic             cfg_wr;

  // word index only; byte offset bits are ignored
  assign reg_sel = (paddr[2] == hpd_pkg::RegMaxPayloadLen);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_sel ? {16'h0000, max_len_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= hpd_pkg::MaxLenReset;
    end else if (cfg_wr && reg_sel) begin
      max_len_q <= pwdata[15:0];
    end
  end

  hpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_item_o  (front_item)
  );

  hpd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  hpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_len_i   (max_len_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {res.payload_len, res.data};
  assign m_axis_tuser = {res.too_long, res.bad_type, res.first, res.is_header, res.kind};
  assign m_axis_tlast = res.last;

endmodule

// ===== sim/tb_hci_h4_packet_deframer_core.sv =====
`timescale 1ns / 1ps

module tb_hci_h4_packet_deframer_core;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 4;   // three-stage path plus one
  localparam logic [2:0] AddrMaxLen = {hpd_pkg::RegMaxPayloadLen, 2'b00};
  localparam logic [2:0] AddrNoReg  = 3'd4;   // past the register list

  // Frame predictor and store of expected output items
  class h4_frame_scoreboard;
    hpd_pkg::result_t frame_q[$];
    logic [15:0]      len_limit;
    hpd_pkg::phase_e  ph;
    logic [15:0]      bytes_left;
    logic [2:0]       hdr_idx;
    logic [7:0]       len_lo;
    hpd_pkg::kind_e   cur_kind;
    logic             oversize;
    int               n_err, n_checked, n_packets, n_bad_type, n_too_long;

    function new();
      len_limit  = hpd_pkg::MaxLenReset;
      n_err      = 0;
      n_checked  = 0;
      n_packets  = 0;
      n_bad_type = 0;
      n_too_long = 0;
      restart();
    endfunction

    function void restart();
      ph         = hpd_pkg::PH_TYPE;
      bytes_left = '0;
      hdr_idx    = '0;
      len_lo     = '0;
      cur_kind   = hpd_pkg::KIND_NONE;
      oversize   = 1'b0;
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      if (idx == 0) len_limit = v[15:0];
    endfunction

    function void note_byte(logic [7:0] b);
      hpd_pkg::result_t r;
      logic [15:0]      len;
      logic             hdr_done;
      r      = '0;
      r.data = b;
      r.kind = hpd_pkg::KIND_NONE;
      case (ph)
        hpd_pkg::PH_HEADER: begin
          r.kind      = cur_kind;
          r.is_header = 1'b1;
          if (cur_kind == hpd_pkg::KIND_EVENT) begin
            hdr_done = (hdr_idx == hpd_pkg::EvtHdrLastIdx);
          end else begin
            if (hdr_idx == hpd_pkg::AclLenLoIdx) len_lo = b;
            hdr_done = (hdr_idx == hpd_pkg::AclHdrLastIdx);
          end
          if (!hdr_done) begin
            hdr_idx = hdr_idx + 3'd1;
          end else begin
            len           = (cur_kind == hpd_pkg::KIND_EVENT) ? {8'h00, b} : {b, len_lo};
            r.payload_len = len;
            r.too_long    = (len > len_limit);
            if (len == 16'd0) begin
              // empty packet ends on its length byte
              r.last = 1'b1;
              restart();
            end else begin
              ph         = hpd_pkg::PH_PAYLOAD;
              bytes_left = len;
              oversize   = r.too_long;
              hdr_idx    = '0;
            end
          end
        end
        hpd_pkg::PH_PAYLOAD: begin
          r.kind     = cur_kind;
          r.too_long = oversize;
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) begin
            r.last = 1'b1;
            restart();
          end
        end
        default: begin
          restart();
          if (b == hpd_pkg::TypeEvent || b == hpd_pkg::TypeAcl) begin
            cur_kind    = (b == hpd_pkg::TypeEvent) ? hpd_pkg::KIND_EVENT : hpd_pkg::KIND_ACL;
            ph          = hpd_pkg::PH_HEADER;
            r.kind      = cur_kind;
            r.is_header = 1'b1;
            r.first     = 1'b1;
            n_packets++;
          end else begin
            r.bad_type = 1'b1;
            n_bad_type++;
          end
        end
      endcase
      if (r.too_long && r.is_header) n_too_long++;
      frame_q.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        n_err++;
      end
    endfunction

    function void check_frame(hpd_pkg::result_t got);
      hpd_pkg::result_t want;
      if (frame_q.size() == 0) begin
        $error("output item with nothing expected: data 0x%0h", got.data);
        n_err++;
        return;
      end
      want = frame_q.pop_front();
      n_checked++;
      cmp_field("data_byte", want.data, got.data);
      cmp_field("packet_kind", want.kind, got.kind);
      cmp_field("is_header", want.is_header, got.is_header);
      cmp_field("first", want.first, got.first);
      cmp_field("last", want.last, got.last);
      cmp_field("bad_type", want.bad_type, got.bad_type);
      cmp_field("too_long", want.too_long, got.too_long);
      cmp_field("payload_len", want.payload_len, got.payload_len);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] data_byte, [23:8] payload_len
  logic [5:0]  m_axis_tuser;   // [1:0] packet_kind, [2] is_header, [3] first,
                               // [4] bad_type, [5] too_long
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  h4_frame_scoreboard sb;
  int  tx_count;
  bit  tx_steady;
  int  idle_cycles;

  hci_h4_packet_deframer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    hpd_pkg::result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got             = '0;
        got.data        = m_axis_tdata[7:0];
        got.payload_len = m_axis_tdata[23:8];
        got.kind        = hpd_pkg::kind_e'(m_axis_tuser[1:0]);
        got.is_header   = m_axis_tuser[2];
        got.first       = m_axis_tuser[3];
        got.bad_type    = m_axis_tuser[4];
        got.too_long    = m_axis_tuser[5];
        got.last        = m_axis_tlast;
        sb.check_frame(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("no progress for %0d cycles", WatchdogLimit);
      $display("hci_h4_packet_deframer_core regression: fail");
      $finish;
    end
  end

  // output backpressure
  initial begin
    int n_on;
    int n_off;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 5) == 0) n_on = $urandom_range(30, 150);
      else n_on = $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (n_on) @(posedge clk_i);
      n_off = pick_gap();
      if (n_off > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n_off) @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    tx_count++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input hpd_pkg::kind_e k, input logic [15:0] len);
    int i;
    if (k == hpd_pkg::KIND_EVENT) begin
      send_byte(hpd_pkg::TypeEvent);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(len[7:0]);
    end else begin
      send_byte(hpd_pkg::TypeAcl);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      send_byte(len[7:0]);
      send_byte(len[15:8]);
    end
    for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // hold the sender until every expected item is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.frame_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(addr[2], v);
  endtask

  task automatic set_limit(input logic [15:0] v);
    drain();
    apb_write(AddrMaxLen, {16'h0000, v});
  endtask

  // mostly well-formed packets, some stray bytes and cut-off headers
  task automatic run_traffic(input int n_items);
    int             stop_at;
    int             r;
    int             i;
    hpd_pkg::kind_e k;
    logic [15:0]    len;
    bit             paused;
    stop_at = tx_count + n_items;
    paused  = 0;
    while (tx_count < stop_at) begin
      tx_steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (r < 14) begin
        send_byte($urandom_range(0, 1) ? hpd_pkg::TypeEvent : hpd_pkg::TypeAcl);
        for (i = 0; i < $urandom_range(0, 2); i++) send_byte(8'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(0, 1) ? hpd_pkg::KIND_EVENT : hpd_pkg::KIND_ACL;
        r = $urandom_range(0, 99);
        if (r < 15) begin
          len = 16'd0;
        end else if (r < 65 || sb.len_limit > 40) begin
          len = 16'($urandom_range(1, 24));
        end else begin
          // around the limit, never below zero
          len = sb.len_limit + 16'($urandom_range(0, 2));
          if (len > 16'd0) len = len - 16'd1;
        end
        if (k == hpd_pkg::KIND_EVENT && len > 16'd255) len = 16'd255;
        send_frame(k, len);
      end
      if (!paused && tx_count > stop_at - n_items / 2) begin
        paused = 1;
        drain();
      end
    end
    tx_steady = 0;
  endtask

  initial begin
    sb            = new();
    tx_count      = 0;
    tx_steady     = 0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unknown types, empty packets, short payloads
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h03);
    send_frame(hpd_pkg::KIND_EVENT, 16'd0);
    send_frame(hpd_pkg::KIND_ACL, 16'd0);
    send_frame(hpd_pkg::KIND_EVENT, 16'd2);
    send_frame(hpd_pkg::KIND_ACL, 16'd1);
    set_limit(16'd0);
    send_frame(hpd_pkg::KIND_EVENT, 16'd1);
    // a write past the register list must leave the limit alone
    drain();
    apb_write(AddrNoReg, 32'h0000_FFFF);
    send_frame(hpd_pkg::KIND_ACL, 16'd1);

    set_limit(16'd0);
    run_traffic(170);
    set_limit(16'd8);
    run_traffic(170);
    set_limit(16'($urandom_range(1, 40)));
    run_traffic(170);
    set_limit(16'hFFFF);
    run_traffic(170);
    set_limit(hpd_pkg::MaxLenReset);
    run_traffic(170);
    set_limit(16'($urandom_range(0, 65535)));
    run_traffic(170);

    // ACL length with a nonzero high byte, one past the limit
    set_limit(16'd259);
    send_frame(hpd_pkg::KIND_ACL, 16'd260);
    // longest event payload
    send_frame(hpd_pkg::KIND_EVENT, 16'd255);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.frame_q.size() != 0) begin
      $error("%0d expected items never came out", sb.frame_q.size());
      sb.n_err++;
    end
    $display("%0d bytes checked: %0d packets, %0d unknown type bytes, %0d oversize",
             sb.n_checked, sb.n_packets, sb.n_bad_type, sb.n_too_long);
    $display("limits swept 0 to 65535, random stalls on both stream sides");
    if (sb.n_err == 0) begin
      $display("hci_h4_packet_deframer_core regression: pass");
    end else begin
      $display("hci_h4_packet_deframer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hpd_pkg.sv
hdl/hpd_front.sv
hdl/hpd_fifo.sv
hdl/hpd_back.sv
hdl/hci_h4_packet_deframer_core.sv
sim/tb_hci_h4_packet_deframer_core.sv
